FILE: sv/scsd_pkg.sv
// scsd_pkg: shared types, codes and tables of the dual stepper drive
`timescale 1ns / 1ps

package scsd_pkg;

  // input word: received byte or time tick
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic [3:0] coil_a;
    logic [3:0] coil_b;
    logic       busy_res;
    logic       last;
  } out_word_t;

  // input kinds
  localparam logic FUNC_RX   = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_COIL = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_BOTH_FWD = 2'd0;
  localparam logic [1:0] DIR_BOTH_REV = 2'd1;
  localparam logic [1:0] DIR_SPIN_L   = 2'd2;
  localparam logic [1:0] DIR_SPIN_R   = 2'd3;

  // command letters
  localparam logic [7:0] CMD_FWD  = 8'h66;  // f
  localparam logic [7:0] CMD_REV  = 8'h61;  // a
  localparam logic [7:0] CMD_LEFT = 8'h69;  // i
  localparam logic [7:0] CMD_RGHT = 8'h64;  // d
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [1:0] LAST_DIGIT = 2'd2;
  localparam logic [4:0] MSG_LEN    = 5'd17;

  // plan of results that one input word causes
  typedef enum logic [1:0] {
    PLAN_BYTE     = 2'd0,
    PLAN_COIL     = 2'd1,
    PLAN_MSG      = 2'd2,
    PLAN_COIL_MSG = 2'd3
  } plan_e;

  // result descriptor passed from control to sequencer
  typedef struct packed {
    plan_e      plan;
    logic [7:0] tx_byte;
    logic [3:0] coil_a;
    logic [3:0] coil_b;
    logic       busy;
  } desc_t;

  // half-step coil sequence
  function automatic logic [3:0] half_step(input logic [2:0] ph);
    logic [3:0] pat;
    case (ph)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hc;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

  // done message with trailing zero
  function automatic logic [7:0] msg_byte(input logic [4:0] k);
    logic [7:0] c;
    case (k)
      5'd0:  c = 8'h41;  // A
      5'd1:  c = 8'h63;  // c
      5'd2:  c = 8'h63;  // c
      5'd3:  c = 8'h69;  // i
      5'd4:  c = 8'h6f;  // o
      5'd5:  c = 8'h6e;  // n
      5'd6:  c = 8'h20;  // space
      5'd7:  c = 8'h72;  // r
      5'd8:  c = 8'h65;  // e
      5'd9:  c = 8'h61;  // a
      5'd10: c = 8'h6c;  // l
      5'd11: c = 8'h69;  // i
      5'd12: c = 8'h7a;  // z
      5'd13: c = 8'h61;  // a
      5'd14: c = 8'h64;  // d
      5'd15: c = 8'h61;  // a
      5'd16: c = 8'h00;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/scsd_ctrl.sv
// scsd_ctrl: command parser, move state and result descriptor register
`timescale 1ns / 1ps

module scsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scsd_pkg::in_word_t in_data_i,
  input  logic [15:0]       step_delay_i,
  output logic              desc_valid_o,
  output scsd_pkg::desc_t   desc_o,
  input  logic              desc_ready_i
);
  import scsd_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_DIGITS = 3'b010,
    MODE_MOVE   = 3'b100
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  dir_q, dir_d;
  logic [1:0]  digit_q, digit_d;
  logic [9:0]  total_q, total_d;
  logic [9:0]  done_q, done_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  pha_q, pha_d, phb_q, phb_d;
  logic [3:0]  appl_a_q, appl_a_d, appl_b_q, appl_b_d;
  logic        pend_valid_q, pend_valid_d;
  desc_t       pend_q, pend_d;

  logic        accept;
  logic        gen;
  logic [7:0]  ch;
  logic        is_digit;
  logic [13:0] total_x10;
  logic [15:0] tick_inc;
  logic [9:0]  done_inc;
  logic        a_fwd, b_fwd;

  assign in_stall_o   = pend_valid_q && !desc_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign desc_valid_o = pend_valid_q;
  assign desc_o       = pend_q;

  assign ch        = in_data_i.rx_byte;
  assign is_digit  = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
  assign total_x10 = ({4'b0, total_q} << 3) + ({4'b0, total_q} << 1) + {10'b0, ch[3:0]};
  assign tick_inc  = tick_q + 16'd1;
  assign done_inc  = done_q + 10'd1;
  assign a_fwd     = (dir_q == DIR_BOTH_FWD) || (dir_q == DIR_SPIN_R);
  assign b_fwd     = (dir_q == DIR_BOTH_FWD) || (dir_q == DIR_SPIN_L);

  // per-word state update and descriptor build
  always_comb begin
    mode_d   = mode_q;
    dir_d    = dir_q;
    digit_d  = digit_q;
    total_d  = total_q;
    done_d   = done_q;
    tick_d   = tick_q;
    pha_d    = pha_q;
    phb_d    = phb_q;
    appl_a_d = appl_a_q;
    appl_b_d = appl_b_q;
    gen      = 1'b0;
    pend_d   = pend_q;
    pend_d.plan    = PLAN_BYTE;
    pend_d.tx_byte = ch;

    if (in_data_i.func == FUNC_RX) begin
      case (mode_q)
        MODE_IDLE: begin
          gen = 1'b1;
          if (ch == CMD_FWD || ch == CMD_REV || ch == CMD_LEFT || ch == CMD_RGHT) begin
            if (ch == CMD_FWD) begin
              dir_d = DIR_BOTH_FWD;
            end else if (ch == CMD_REV) begin
              dir_d = DIR_BOTH_REV;
            end else if (ch == CMD_LEFT) begin
              dir_d = DIR_SPIN_L;
            end else begin
              dir_d = DIR_SPIN_R;
            end
            digit_d = 2'd0;
            total_d = 10'd0;
            mode_d  = MODE_DIGITS;
            pend_d.tx_byte = ch - CASE_OFS;
          end else begin
            pend_d.plan = PLAN_MSG;
          end
        end
        MODE_DIGITS: begin
          if (is_digit) begin
            gen     = 1'b1;
            total_d = total_x10[9:0];
            digit_d = digit_q + 2'd1;
            if (digit_q == LAST_DIGIT) begin
              digit_d = 2'd0;
              done_d  = 10'd0;
              tick_d  = 16'd0;
              mode_d  = MODE_MOVE;
            end
          end
        end
        default: ;
      endcase
    end else if (mode_q == MODE_MOVE) begin
      tick_d = tick_inc;
      if (tick_inc >= step_delay_i) begin
        gen         = 1'b1;
        tick_d      = 16'd0;
        appl_a_d    = half_step(pha_q);
        appl_b_d    = half_step(phb_q);
        pend_d.plan = PLAN_COIL;
        if (done_q < total_q) begin
          pha_d = a_fwd ? pha_q + 3'd1 : pha_q - 3'd1;
          phb_d = b_fwd ? phb_q + 3'd1 : phb_q - 3'd1;
        end
        done_d = done_inc;
        if (done_inc > total_q) begin
          mode_d      = MODE_IDLE;
          done_d      = 10'd0;
          pend_d.plan = PLAN_COIL_MSG;
        end
      end
    end

    pend_d.coil_a = appl_a_d;
    pend_d.coil_b = appl_b_d;
    pend_d.busy   = (mode_d != MODE_IDLE);

    // descriptor slot: filled by a word with results, emptied on hand-off
    pend_valid_d = pend_valid_q && !desc_ready_i;
    if (accept && gen) begin
      pend_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      dir_q        <= DIR_BOTH_FWD;
      digit_q      <= 2'd0;
      total_q      <= 10'd0;
      done_q       <= 10'd0;
      tick_q       <= 16'd0;
      pha_q        <= 3'd0;
      phb_q        <= 3'd0;
      appl_a_q     <= 4'd0;
      appl_b_q     <= 4'd0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        mode_q   <= mode_d;
        dir_q    <= dir_d;
        digit_q  <= digit_d;
        total_q  <= total_d;
        done_q   <= done_d;
        tick_q   <= tick_d;
        pha_q    <= pha_d;
        phb_q    <= phb_d;
        appl_a_q <= appl_a_d;
        appl_b_q <= appl_b_d;
      end
    end
  end

  // descriptor payload
  always_ff @(posedge clk_i) begin
    if (accept && gen) begin
      pend_q <= pend_d;
    end
  end

`ifndef ASSERT_OFF
  // a queued descriptor waits unchanged until the sequencer takes it
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !desc_ready_i |=> pend_valid_q && $stable(pend_q))
    else $error("queued descriptor lost or changed");

  // a move always ends with the message plan and not busy
  a_end_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_q == MODE_MOVE && mode_d == MODE_IDLE |=>
      pend_valid_q && pend_q.plan == PLAN_COIL_MSG && !pend_q.busy)
    else $error("move end without done message");

  // the digit counter never passes the third digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q != 2'd3)
    else $error("digit counter out of range");
`endif

endmodule

FILE: sv/scsd_emit.sv
// scsd_emit: result sequencer that expands a descriptor into result words
`timescale 1ns / 1ps

module scsd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               desc_valid_i,
  input  scsd_pkg::desc_t    desc_i,
  output logic               desc_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scsd_pkg::out_word_t out_data_o
);
  import scsd_pkg::*;

  desc_t      cur_q;
  logic       act_q;
  logic [4:0] idx_q;

  logic       has_coil;
  logic       coil_slot;
  logic       is_last;
  logic [4:0] last_idx;
  logic [4:0] msg_idx;
  logic       out_fire;

  assign has_coil  = (cur_q.plan == PLAN_COIL) || (cur_q.plan == PLAN_COIL_MSG);
  assign coil_slot = has_coil && (idx_q == 5'd0);
  assign msg_idx   = has_coil ? idx_q - 5'd1 : idx_q;

  // index of the final word of the plan
  always_comb begin
    case (cur_q.plan)
      PLAN_BYTE:     last_idx = 5'd0;
      PLAN_COIL:     last_idx = 5'd0;
      PLAN_MSG:      last_idx = MSG_LEN - 5'd1;
      PLAN_COIL_MSG: last_idx = MSG_LEN;
      default:       last_idx = 5'd0;
    endcase
  end

  assign is_last      = (idx_q == last_idx);
  assign out_fire     = act_q && !out_stall_i;
  assign desc_ready_o = !act_q || (out_fire && is_last);
  assign out_valid_o  = act_q;

  // result word from the current descriptor and index
  always_comb begin
    out_data_o.result_kind = coil_slot ? KIND_COIL : KIND_TX;
    if (coil_slot) begin
      out_data_o.tx_byte = 8'h00;
    end else if (cur_q.plan == PLAN_BYTE) begin
      out_data_o.tx_byte = cur_q.tx_byte;
    end else begin
      out_data_o.tx_byte = msg_byte(msg_idx);
    end
    out_data_o.coil_a   = cur_q.coil_a;
    out_data_o.coil_b   = cur_q.coil_b;
    out_data_o.busy_res = cur_q.busy;
    out_data_o.last     = is_last;
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= 5'd0;
    end else if (desc_valid_i && desc_ready_o) begin
      act_q <= 1'b1;
      idx_q <= 5'd0;
    end else if (out_fire) begin
      if (is_last) begin
        act_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

  // descriptor payload
  always_ff @(posedge clk_i) begin
    if (desc_valid_i && desc_ready_o) begin
      cur_q <= desc_i;
    end
  end

`ifndef ASSERT_OFF
  // a stalled plan stays active and holds its index
  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && out_stall_i |=> act_q && idx_q == $past(idx_q))
    else $error("result sequence dropped during stall");

  // words of one plan come in index order with the same busy flag
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !is_last |=> act_q && idx_q == $past(idx_q) + 5'd1 &&
      cur_q.busy == $past(cur_q.busy))
    else $error("result index skipped or plan replaced early");

  // only the coil slot carries a coil result
  a_coil_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_COIL |-> idx_q == 5'd0 && has_coil)
    else $error("coil result out of place");
`endif

endmodule

FILE: sv/serial_commanded_dual_stepper_drive.sv
// serial_commanded_dual_stepper_drive: top level with register port and datapath
`timescale 1ns / 1ps

// Serial-commanded drive for two four-coil steppers in half steps. Each input word
// is a received byte or a 100 us tick; it is accepted at an edge where in_stall_o
// is low, and the command state, phase indices and tick counter are updated at
// that edge. A word yields zero to eighteen result words (echo byte, coil pattern,
// done message), which a sequencer delivers one per cycle while the output is not
// stalled. One word's results may be queued behind the ones being delivered, so
// input words flow at one per cycle as long as each causes at most one result and
// the output is not stalled; after a done message the input waits until the
// queued plan moves into the sequencer. Register step_delay (offset 0, reset 200)
// sets the ticks between coil updates; write it only while no move is in progress.

module serial_commanded_dual_stepper_drive (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scsd_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scsd_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import scsd_pkg::*;

  localparam logic [15:0] STEP_DELAY_RST = 16'd200;

  logic [15:0] step_delay_q;
  logic        reg_sel;
  logic        desc_valid;
  logic        desc_ready;
  desc_t       desc;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {16'd0, step_delay_q} : 32'd0;

  // step delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q <= STEP_DELAY_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      step_delay_q <= pwdata[15:0];
    end
  end

  scsd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .step_delay_i (step_delay_q),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_ready_i (desc_ready)
  );

  scsd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_ready_o (desc_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: tb/sv/serial_commanded_dual_stepper_drive_tb.sv
// serial_commanded_dual_stepper_drive_tb: self-checking regression of the dual stepper drive
`timescale 1ns / 1ps

module serial_commanded_dual_stepper_drive_tb;
  import scsd_pkg::*;

  // command state of the drive as tracked by the scoreboard
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DIGITS = 2'd1,
    MODE_MOVE   = 2'd2
  } drive_mode_e;

  localparam logic [2:0]  ADDR_STEP_DELAY = 3'd0;
  localparam logic [15:0] RESET_DELAY     = 16'd200;
  localparam int          DONE_MSG_BYTES  = 17;
  localparam int          DRAIN_LIMIT     = 5000;
  localparam int          SETTLE_CYCLES   = 20;
  localparam logic [7:0]  CHR_E           = 8'h65;
  localparam logic [7:0]  CHR_L           = 8'h4c;
  localparam logic [7:0]  CHR_X           = 8'h78;

  // drive model and queue of expected result words
  class stepper_scoreboard;
    logic [15:0] step_delay;
    drive_mode_e mode;
    logic [1:0]  direction;
    logic [1:0]  digit_count;
    logic [9:0]  step_total;
    logic [9:0]  step_done;
    logic [15:0] tick_count;
    logic [2:0]  phase_a;
    logic [2:0]  phase_b;
    logic [3:0]  coil_a;
    logic [3:0]  coil_b;
    logic [3:0]  coil_seq [8];
    string       done_text;
    out_word_t   batch[$];
    out_word_t   pending[$];
    int          errors;
    int          checked;
    int          acted;

    function new();
      coil_seq    = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9};
      done_text   = "Accion realizada";
      step_delay  = RESET_DELAY;
      mode        = MODE_IDLE;
      direction   = DIR_BOTH_FWD;
      digit_count = '0;
      step_total  = '0;
      step_done   = '0;
      tick_count  = '0;
      phase_a     = '0;
      phase_b     = '0;
      coil_a      = '0;
      coil_b      = '0;
      errors      = 0;
      checked     = 0;
      acted       = 0;
    endfunction

    function out_word_t make_word(logic kind, logic [7:0] b);
      out_word_t r;
      r.result_kind = kind;
      r.tx_byte     = b;
      r.coil_a      = coil_a;
      r.coil_b      = coil_b;
      r.busy_res    = 1'b0;
      r.last        = 1'b0;
      return r;
    endfunction

    // done message with its trailing zero
    function void add_message();
      for (int k = 0; k < DONE_MSG_BYTES; k++) begin
        batch.push_back(make_word(KIND_TX, (k < done_text.len()) ? done_text[k] : 8'h00));
      end
    endfunction

    // update the model with one accepted word and queue what it causes
    function void note_word(in_word_t w);
      logic [1:0] dir;
      bit         is_cmd;
      batch.delete();
      if (w.func == FUNC_RX) begin
        case (mode)
          MODE_IDLE: begin
            acted++;
            is_cmd = 1'b1;
            dir    = DIR_BOTH_FWD;
            case (w.rx_byte)
              CMD_FWD:  dir = DIR_BOTH_FWD;
              CMD_REV:  dir = DIR_BOTH_REV;
              CMD_LEFT: dir = DIR_SPIN_L;
              CMD_RGHT: dir = DIR_SPIN_R;
              default:  is_cmd = 1'b0;
            endcase
            if (is_cmd) begin
              direction   = dir;
              digit_count = '0;
              step_total  = '0;
              mode        = MODE_DIGITS;
              batch.push_back(make_word(KIND_TX, w.rx_byte - CASE_OFS));
            end else begin
              add_message();
            end
          end
          MODE_DIGITS: begin
            // non-digits are dropped silently
            if (w.rx_byte >= CHR_ZERO && w.rx_byte <= CHR_NINE) begin
              acted++;
              step_total = 10'(step_total * 10 + (w.rx_byte - CHR_ZERO));
              batch.push_back(make_word(KIND_TX, w.rx_byte));
              if (digit_count == LAST_DIGIT) begin
                digit_count = '0;
                step_done   = '0;
                tick_count  = '0;
                mode        = MODE_MOVE;
              end else begin
                digit_count = digit_count + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end else if (mode == MODE_MOVE) begin
        acted++;
        tick_count = tick_count + 16'd1;
        // a zero delay acts as one tick
        if (tick_count >= step_delay) begin
          tick_count = '0;
          coil_a     = coil_seq[phase_a];
          coil_b     = coil_seq[phase_b];
          batch.push_back(make_word(KIND_COIL, 8'h00));
          if (step_done < step_total) begin
            phase_a = (direction == DIR_BOTH_FWD || direction == DIR_SPIN_R) ?
                      phase_a + 3'd1 : phase_a - 3'd1;
            phase_b = (direction == DIR_BOTH_FWD || direction == DIR_SPIN_L) ?
                      phase_b + 3'd1 : phase_b - 3'd1;
          end
          step_done = step_done + 10'd1;
          if (step_done > step_total) begin
            mode      = MODE_IDLE;
            step_done = '0;
            add_message();
          end
        end
      end
      // busy and last flags are known only once the word is handled
      foreach (batch[k]) begin
        batch[k].busy_res = (mode != MODE_IDLE);
        batch[k].last     = (k == batch.size() - 1);
        pending.push_back(batch[k]);
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [7:0] got_v, logic [7:0] exp_v);
      if (got_v !== exp_v) begin
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got_v, exp_v));
      end
    endtask

    // compare one delivered result word with the oldest expectation
    task check_result(out_word_t got);
      out_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      exp_w = pending.pop_front();
      compare_field("result_kind", 8'(got.result_kind), 8'(exp_w.result_kind));
      compare_field("tx_byte", got.tx_byte, exp_w.tx_byte);
      compare_field("coil_a", 8'(got.coil_a), 8'(exp_w.coil_a));
      compare_field("coil_b", 8'(got.coil_b), 8'(exp_w.coil_b));
      compare_field("busy_res", 8'(got.busy_res), 8'(exp_w.busy_res));
      compare_field("last", 8'(got.last), 8'(exp_w.last));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  stepper_scoreboard sb;
  int words_accepted = 0;
  int in_gap_max     = 19;
  int out_gap_max    = 19;
  int stall_left     = 0;
  int delays_written = 0;

  serial_commanded_dual_stepper_drive DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // accepted words on both sides, and the receiver's random stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_word(in_data_i);
        words_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        stall_left = $urandom_range(0, out_gap_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // present one word after a random gap and wait until it is taken
  task automatic send_word(input in_word_t w);
    int gap;
    int target;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    target = words_accepted + 1;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    wait (words_accepted == target);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_word_t w;
    w.func    = FUNC_RX;
    w.rx_byte = b;
    send_word(w);
  endtask

  // tick with a random don't-care byte
  task automatic send_tick();
    in_word_t w;
    w.func    = FUNC_TICK;
    w.rx_byte = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // non-digit byte or tick
  task automatic send_junk();
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) begin
      send_tick();
    end else begin
      do b = 8'($urandom_range(0, 255)); while (b >= CHR_ZERO && b <= CHR_NINE);
      send_byte(b);
    end
  endtask

  // tick until the move ends, with a few stray bytes
  task automatic run_move();
    while (sb.mode == MODE_MOVE) begin
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_tick();
    end
  endtask

  // bring the drive back to idle
  task automatic finish_command();
    while (sb.mode == MODE_DIGITS) send_byte(CHR_ZERO);
    run_move();
  endtask

  // three digit count below twenty, with some junk in between
  task automatic send_count();
    logic [7:0] digits [3];
    digits[0] = CHR_ZERO;
    digits[1] = ($urandom_range(0, 3) == 0) ? CHR_ZERO + 8'($urandom_range(0, 1)) : CHR_ZERO;
    digits[2] = CHR_ZERO + 8'($urandom_range(0, 9));
    foreach (digits[k]) begin
      if ($urandom_range(0, 7) == 0) send_junk();
      send_byte(digits[k]);
    end
  endtask

  // one random command: mostly complete, some noise and broken ones
  task automatic run_sequence();
    int         pick;
    logic [7:0] letters [4];
    letters = '{CMD_FWD, CMD_REV, CMD_LEFT, CMD_RGHT};
    pick    = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) == 0) send_tick();
        else send_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick == 1) begin
      send_byte(letters[2'($urandom_range(0, 3))]);
      repeat ($urandom_range(0, 2)) send_byte(CHR_ZERO + 8'($urandom_range(0, 2)));
      repeat ($urandom_range(1, 3)) send_junk();
    end else begin
      send_byte(letters[2'($urandom_range(0, 3))]);
      send_count();
      run_move();
    end
  endtask

  // let every expected word arrive, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write: setup then access
  task automatic write_delay(input logic [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STEP_DELAY;
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.step_delay = v;
    delays_written++;
  endtask

  // stimulus
  initial begin
    logic [15:0] phase_delays [4];
    int          phase_in_gap [5];
    int          phase_out_gap [5];
    int          target;
    phase_delays  = '{16'd1, 16'd3, 16'd0, 16'd2};
    phase_in_gap  = '{19, 0, 19, 0, 7};
    phase_out_gap = '{19, 0, 0, 19, 7};
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle bytes that only send the done message, stray ticks
    send_byte(CHR_E);
    send_byte(CHR_L);
    send_byte(8'h00);
    send_byte(8'hff);
    send_tick();
    // non-digits while collecting, a few ticks at the reset delay,
    // then the delay lowered below the count in the middle of the move
    send_byte(CMD_FWD);
    send_byte(CHR_X);
    send_byte(CHR_ZERO - 8'd1);
    send_byte(CHR_NINE + 8'd1);
    send_tick();
    repeat (3) send_byte(CHR_ZERO);
    send_byte(CMD_FWD);
    repeat (5) send_tick();
    drain_results();
    write_delay(16'd3);
    run_move();
    drain_results();

    // zero delay, reverse and both spin directions, a two digit count
    write_delay(16'd0);
    send_byte(CMD_REV);
    send_byte(CHR_ZERO);
    send_byte(CHR_ZERO);
    send_byte(CHR_ZERO + 8'd3);
    run_move();
    send_byte(CMD_LEFT);
    send_byte(CHR_ZERO);
    send_byte(CHR_ZERO);
    send_byte(CHR_ZERO + 8'd2);
    run_move();
    send_byte(CMD_RGHT);
    send_byte(CHR_ZERO);
    send_byte(CHR_ZERO + 8'd1);
    send_byte(CHR_ZERO);
    run_move();
    drain_results();

    // largest delay with ticks back to back, then lowered below the count
    write_delay(16'hffff);
    in_gap_max = 0;
    send_byte(CMD_FWD);
    repeat (3) send_byte(CHR_ZERO);
    repeat (4) send_tick();
    drain_results();
    write_delay(16'd2);
    run_move();
    drain_results();

    // random phases at several small delays and idling mixes
    for (int p = 0; p < 5; p++) begin
      write_delay((p < 4) ? phase_delays[p] : 16'($urandom_range(0, 4)));
      in_gap_max  = phase_in_gap[p];
      out_gap_max = phase_out_gap[p];
      target      = sb.acted + 48;
      while (sb.acted < target) run_sequence();
      finish_command();
      drain_results();
    end

    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
    end
    $display("covered %0d input words (%0d acted on) over %0d delay settings",
             words_accepted, sb.acted, delays_written);
    $display("checked %0d result words, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("serial_commanded_dual_stepper_drive regression: pass");
    end else begin
      $display("serial_commanded_dual_stepper_drive regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("serial_commanded_dual_stepper_drive regression: fail");
    $finish;
  end

endmodule
